// ===== src/vm3_pkg.sv =====
// Shared widths, types and constants for the 3-D vector magnitude block.
package vm3_pkg;

   localparam int COMP_W               = 24;
   localparam int SQ_W                 = 2 * COMP_W;
   localparam int ROOT_W               = SQ_W / 2;
   localparam int REM_W                = ROOT_W + 2;
   localparam int SQRT_STEPS           = SQ_W / 2;
   localparam int SQRT_STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES          = SQRT_STEPS / SQRT_STEPS_PER_STAGE;

   // Largest possible sum of squares: three components of magnitude 2^23.
   localparam logic [SQ_W-1:0] SUM_MAX = 48'hC000_0000_0000;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic [ROOT_W-1:0]        mag_type;

   // Running state of the digit-by-digit square root.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      mag_type          root;
      logic [SQ_W-1:0]  rad;
      logic             last;
   } sqrt_state_type;

endpackage

// ===== src/vm3_req_if.sv =====
// Request channel: one vector per beat.
interface vm3_req_if;
   logic              valid;
   logic              ready;
   vm3_pkg::comp_type comp_x;
   vm3_pkg::comp_type comp_y;
   vm3_pkg::comp_type comp_z;
   logic              last_row;

   modport source (output valid, output comp_x, output comp_y, output comp_z,
                   output last_row, input ready);
   modport sink (input valid, input comp_x, input comp_y, input comp_z,
                 input last_row, output ready);
endinterface

// ===== src/vm3_rsp_if.sv =====
// Response channel: one magnitude per beat.
interface vm3_rsp_if;
   logic             valid;
   logic             ready;
   vm3_pkg::mag_type magnitude;
   logic             last_out;

   modport source (output valid, output magnitude, output last_out, input ready);
   modport sink (input valid, input magnitude, input last_out, output ready);
endinterface

// ===== src/vector_magnitude_3d.sv =====
// Top level of the 3-D vector magnitude pipeline.
//
// vector_magnitude_3d: each request beat carries three signed 24-bit
// components at one common scale plus a last-row flag; each response beat
// carries floor(sqrt(x*x + y*y + z*z)) as a 24-bit unsigned value at the
// same scale, with the flag copied through. The sum of squares is exact
// (48 bits) and the result never exceeds 14529495, so nothing saturates.
// Throughput is one beat per clock unless the response side stalls. There
// are 15 register stages: three front-end stages (absolute value, squaring,
// three-way add) and twelve root stages, since the 24-digit restoring square
// root retires two digits per stage.
// Every stage has its own valid bit and advances whenever its successor is
// empty or moving, so back-pressure on the response side fills bubbles
// first and drops nothing; the last root stage is the response register.
// There is no configuration and no state carried between beats.
module vector_magnitude_3d (
   input  logic  clock,
   input  logic  reset,
   vm3_req_if.sink   req_chan,
   vm3_rsp_if.source rsp_chan
);

   localparam int N = vm3_pkg::SQRT_STAGES;

   // Handshake chain: index 0 is the front-end output, N the response.
   logic                    chain_valid [N+1];
   logic                    chain_ready [N+1];
   vm3_pkg::sqrt_state_type chain_state [N+1];

   vm3_sumsq u_sumsq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .comp_x    (req_chan.comp_x),
      .comp_y    (req_chan.comp_y),
      .comp_z    (req_chan.comp_z),
      .last_row  (req_chan.last_row),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_state (chain_state[0])
   );

   for (genvar g = 0; g < N; g++) begin : g_root
      vm3_sqrt_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_state  (chain_state[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_state (chain_state[g+1])
      );
   end

   // Response beat comes straight from the last root stage register.
   assign chain_ready[N]     = rsp_chan.ready;
   assign rsp_chan.valid     = chain_valid[N];
   assign rsp_chan.magnitude = chain_state[N].root;
   assign rsp_chan.last_out  = chain_state[N].last;

`ifndef SYNTH
   // Sum of squares of three 24-bit components never exceeds 3 * 2^46.
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      chain_valid[0] |-> chain_state[0].rad <= vm3_pkg::SUM_MAX)
      else $error("sum of squares out of range");

   // Floor root: the final remainder is at most twice the root.
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      chain_valid[N] |-> chain_state[N].rem <= {1'b0, chain_state[N].root, 1'b0})
      else $error("root remainder too large");

   // A stalled response register keeps its item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      chain_valid[N] && !chain_ready[N] |=> chain_valid[N] && $stable(chain_state[N]))
      else $error("stalled response item changed");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !chain_valid[0])
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== src/vm3_sumsq.sv =====
// Three-stage front end: absolute values, squares, sum of squares.
module vm3_sumsq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  vm3_pkg::comp_type       comp_x,
   input  vm3_pkg::comp_type       comp_y,
   input  vm3_pkg::comp_type       comp_z,
   input  logic                    last_row,
   output logic                    out_valid,
   input  logic                    out_ready,
   output vm3_pkg::sqrt_state_type out_state
);

   logic                              abs_valid_ff, sq_valid_ff, sum_valid_ff;
   logic                              abs_en, sq_en, sum_en;
   logic [vm3_pkg::COMP_W-1:0]        abs_x_ff, abs_y_ff, abs_z_ff;
   logic [vm3_pkg::COMP_W-1:0]        abs_x_in, abs_y_in, abs_z_in;
   logic                              abs_last_ff;
   logic [vm3_pkg::SQ_W-1:0]          sq_x_ff, sq_y_ff, sq_z_ff;
   logic [vm3_pkg::SQ_W-1:0]          sq_x_in, sq_y_in, sq_z_in;
   logic                              sq_last_ff;
   vm3_pkg::sqrt_state_type           sum_ff, sum_in;

   assign sum_en   = !sum_valid_ff || out_ready;
   assign sq_en    = !sq_valid_ff || sum_en;
   assign abs_en   = !abs_valid_ff || sq_en;
   assign in_ready = abs_en;

   // -2^23 maps to 2^23, which still fits the unsigned 24 bits.
   assign abs_x_in = comp_x[vm3_pkg::COMP_W-1] ? (~comp_x + 1'b1) : comp_x;
   assign abs_y_in = comp_y[vm3_pkg::COMP_W-1] ? (~comp_y + 1'b1) : comp_y;
   assign abs_z_in = comp_z[vm3_pkg::COMP_W-1] ? (~comp_z + 1'b1) : comp_z;

   assign sq_x_in = abs_x_ff * abs_x_ff;
   assign sq_y_in = abs_y_ff * abs_y_ff;
   assign sq_z_in = abs_z_ff * abs_z_ff;

   always_comb begin
      sum_in      = '0;
      sum_in.rad  = sq_x_ff + sq_y_ff + sq_z_ff;
      sum_in.last = sq_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (abs_en) begin
            abs_valid_ff <= in_valid;
         end
         if (sq_en) begin
            sq_valid_ff <= abs_valid_ff;
         end
         if (sum_en) begin
            sum_valid_ff <= sq_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (abs_en && in_valid) begin
         abs_x_ff    <= abs_x_in;
         abs_y_ff    <= abs_y_in;
         abs_z_ff    <= abs_z_in;
         abs_last_ff <= last_row;
      end
      if (sq_en && abs_valid_ff) begin
         sq_x_ff    <= sq_x_in;
         sq_y_ff    <= sq_y_in;
         sq_z_ff    <= sq_z_in;
         sq_last_ff <= abs_last_ff;
      end
      if (sum_en && sq_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_state = sum_ff;

endmodule

// ===== src/vm3_sqrt_stage.sv =====
// One square-root stage: two radix-2 root digits per register.
module vm3_sqrt_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  vm3_pkg::sqrt_state_type in_state,
   output logic                    out_valid,
   input  logic                    out_ready,
   output vm3_pkg::sqrt_state_type out_state
);

   logic                    valid_ff, valid_in;
   vm3_pkg::sqrt_state_type state_ff, state_in;

   // Bring down two radicand bits, try (4*root + 1), keep it if it fits.
   function automatic vm3_pkg::sqrt_state_type sqrt_step(
      input vm3_pkg::sqrt_state_type s
   );
      logic [vm3_pkg::REM_W+1:0] cur;
      logic [vm3_pkg::REM_W+1:0] trial;
      logic [vm3_pkg::REM_W+1:0] diff;
      vm3_pkg::sqrt_state_type   r;
      cur   = {s.rem, s.rad[vm3_pkg::SQ_W-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      diff  = cur - trial;
      r     = s;
      r.rad = {s.rad[vm3_pkg::SQ_W-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = diff[vm3_pkg::REM_W-1:0];
         r.root = {s.root[vm3_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = cur[vm3_pkg::REM_W-1:0];
         r.root = {s.root[vm3_pkg::ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      state_in = in_state;
      for (int i = 0; i < vm3_pkg::SQRT_STEPS_PER_STAGE; i++) begin
         state_in = sqrt_step(state_in);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== tb/sv/vector_magnitude_3d_test.sv =====
// Self-checking testbench for the 3-D vector magnitude pipeline.
module vector_magnitude_3d_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam vm3_pkg::comp_type COMP_MIN = vm3_pkg::comp_type'(24'h80_0000);
   localparam vm3_pkg::comp_type COMP_MAX = vm3_pkg::comp_type'(24'h7F_FFFF);
   localparam int       RANDOM_ROWS = 1600;
   localparam int       STALL_LIMIT = 5000;  // cycles with no beat on either side
   localparam int       TAIL_CYCLES = 40;    // pipeline is 15 deep
   localparam int       CALM_FROM   = 700;   // no idling on either side in this window
   localparam int       CALM_TO     = 1000;

   typedef struct {
      vm3_pkg::comp_type x;
      vm3_pkg::comp_type y;
      vm3_pkg::comp_type z;
      logic              last_row;
      logic              wait_drain;  // hold this row back until the pipe is empty
   } row_type;

   typedef struct {
      vm3_pkg::mag_type magnitude;
      logic             last_out;
   } norm_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vm3_req_if req_bus ();
   vm3_rsp_if rsp_bus ();

   vector_magnitude_3d dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   row_type  rows_to_send[$];
   norm_type norm_expected[$];

   logic req_fire    = 1'b0;  // request beat taken at the last rising edge
   int   rows_in     = 0;
   int   rows_out    = 0;
   int   table_ends  = 0;
   int   fault_count = 0;
   int   stall_count = 0;
   int   peak_mag    = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Exact floor of the Euclidean norm: sum of squares in 64-bit integers, then the
   // root built from the top bit down, keeping each bit whose square still fits.
   function automatic norm_type euclid_norm(row_type row);
      longint          axis[3];
      longint unsigned sum_sq;
      longint unsigned root;
      longint unsigned trial;
      norm_type        res;
      axis[0] = longint'(row.x);
      axis[1] = longint'(row.y);
      axis[2] = longint'(row.z);
      sum_sq  = 0;
      foreach (axis[k]) begin
         if (axis[k] < 0) axis[k] = -axis[k];
         sum_sq += longint'(axis[k]) * longint'(axis[k]);
      end
      root = 0;
      for (int b = vm3_pkg::ROOT_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sum_sq) root = trial;
      end
      res.magnitude = vm3_pkg::mag_type'(root);
      res.last_out  = row.last_row;
      return res;
   endfunction

   task automatic queue_row(vm3_pkg::comp_type x, vm3_pkg::comp_type y,
                            vm3_pkg::comp_type z, logic last_row,
                            logic wait_drain = 1'b0);
      row_type row;
      row.x          = x;
      row.y          = y;
      row.z          = z;
      row.last_row   = last_row;
      row.wait_drain = wait_drain;
      rows_to_send.insert(rows_to_send.size(), row);
   endtask

   function automatic vm3_pkg::comp_type pick_extreme();
      case ($urandom_range(4))
         0:       return COMP_MIN;
         1:       return vm3_pkg::comp_type'(-1);
         2:       return vm3_pkg::comp_type'(0);
         3:       return vm3_pkg::comp_type'(1);
         default: return COMP_MAX;
      endcase
   endfunction

   function automatic vm3_pkg::comp_type small_comp(int span);
      return vm3_pkg::comp_type'(int'($urandom_range(2 * span - 1)) - span);
   endfunction

   task automatic flag_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // Driver: request side changes on the falling edge. A beat offered stays
   // put until it is taken; otherwise the next row goes out unless this
   // cycle is an idle one or the row is waiting for the pipe to drain.
   always @(negedge clock) begin
      logic    go;
      row_type row;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !req_fire)) begin
         go = rows_to_send.size() != 0;
         if (go && rows_to_send[0].wait_drain && norm_expected.size() != 0) go = 1'b0;
         if (go && !(rows_in >= CALM_FROM && rows_in < CALM_TO) && $urandom_range(99) < 24)
            go = 1'b0;
         if (go) begin
            row = rows_to_send.pop_front();
            req_bus.comp_x   <= row.x;
            req_bus.comp_y   <= row.y;
            req_bus.comp_z   <= row.z;
            req_bus.last_row <= row.last_row;
         end else begin
            // junk payload while idle, must be ignored
            req_bus.comp_x   <= vm3_pkg::comp_type'($urandom());
            req_bus.comp_y   <= vm3_pkg::comp_type'($urandom());
            req_bus.comp_z   <= vm3_pkg::comp_type'($urandom());
            req_bus.last_row <= 1'($urandom());
         end
         req_bus.valid <= go;
      end
   end

   // Response side back-pressure, also on the falling edge.
   always @(negedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else if (rows_out >= CALM_FROM && rows_out < CALM_TO)
         rsp_bus.ready <= 1'b1;
      else
         rsp_bus.ready <= $urandom_range(99) >= 24;
   end

   // Monitor: both channels sampled on the rising edge. The response is
   // checked before the new request is predicted, so a stray response can
   // never be matched against a row taken on the same edge.
   always @(posedge clock) begin
      norm_type want;
      norm_type row_norm;
      row_type  row;
      if (reset) begin
         req_fire    <= 1'b0;
         stall_count <= 0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_count <= 0;
         else
            stall_count <= stall_count + 1;

         if (rsp_bus.valid && rsp_bus.ready) begin
            rows_out++;
            if (rsp_bus.last_out === 1'b1) table_ends++;
            if (norm_expected.size() == 0) begin
               flag_fault($sformatf("unexpected beat magnitude=%0d last_out=%b",
                                    rsp_bus.magnitude, rsp_bus.last_out));
            end else begin
               want = norm_expected.pop_front();
               if (rsp_bus.magnitude !== want.magnitude)
                  flag_fault($sformatf("beat %0d magnitude expected %0d got %0d",
                                       rows_out, want.magnitude, rsp_bus.magnitude));
               if (rsp_bus.last_out !== want.last_out)
                  flag_fault($sformatf("beat %0d last_out expected %b got %b",
                                       rows_out, want.last_out, rsp_bus.last_out));
            end
         end

         if (req_bus.valid && req_bus.ready) begin
            row.x        = req_bus.comp_x;
            row.y        = req_bus.comp_y;
            row.z        = req_bus.comp_z;
            row.last_row = req_bus.last_row;
            row_norm     = euclid_norm(row);
            if (int'(row_norm.magnitude) > peak_mag) peak_mag = int'(row_norm.magnitude);
            norm_expected.insert(norm_expected.size(), row_norm);
            rows_in++;
         end
      end
   end

   initial begin
      int                table_left;
      int                kind;
      logic              last_flag;
      vm3_pkg::comp_type cx, cy, cz;

      req_bus.valid    = 1'b0;
      req_bus.comp_x   = '0;
      req_bus.comp_y   = '0;
      req_bus.comp_z   = '0;
      req_bus.last_row = 1'b0;
      rsp_bus.ready    = 1'b0;

      // directed rows: zero vector, extremes, most negative component
      // in each slot, small exact cases and both flag values
      queue_row(0, 0, 0, 1'b0);
      queue_row(COMP_MAX, COMP_MAX, COMP_MAX, 1'b0);
      queue_row(COMP_MIN, COMP_MIN, COMP_MIN, 1'b1);   // largest magnitude
      queue_row(COMP_MIN, 0, 0, 1'b0);
      queue_row(0, COMP_MIN, 0, 1'b0);
      queue_row(0, 0, COMP_MIN, 1'b1);
      queue_row(COMP_MAX, 0, 0, 1'b0);
      queue_row(0, COMP_MAX, 0, 1'b0);
      queue_row(0, 0, COMP_MAX, 1'b0);
      queue_row(COMP_MIN, COMP_MAX, 0, 1'b1);
      queue_row(COMP_MAX, COMP_MIN, COMP_MIN, 1'b0);
      queue_row(1, 0, 0, 1'b0);
      queue_row(-1, -1, -1, 1'b0);
      queue_row(3, 4, 0, 1'b1);
      queue_row(-2, 3, -6, 1'b0);
      queue_row(1, 1, 0, 1'b0);
      queue_row(4095, 1, 0, 1'b0);                      // just above a square
      queue_row(4095, 90, 0, 1'b0);                     // just below the next one
      queue_row(-1, COMP_MAX, COMP_MAX, 1'b1);
      queue_row(vm3_pkg::comp_type'(24'h55_5555), vm3_pkg::comp_type'(24'hAA_AAAA),
                vm3_pkg::comp_type'(24'hFF_FFFF), 1'b0);

      // random rows grouped into tables of random length, last row flagged
      table_left = $urandom_range(40, 1);
      for (int i = 0; i < RANDOM_ROWS; i++) begin
         kind = $urandom_range(9);
         case (kind)
            4, 5: begin
               cx = small_comp(64);
               cy = small_comp(64);
               cz = small_comp(64);
            end
            6: begin
               cx = pick_extreme();
               cy = pick_extreme();
               cz = pick_extreme();
            end
            7: begin
               // one big axis, tiny others: sum sits right next to a square
               cx = vm3_pkg::comp_type'($urandom());
               cy = small_comp(2);
               cz = small_comp(2);
            end
            8: begin
               cx = vm3_pkg::comp_type'($urandom());
               cy = vm3_pkg::comp_type'($urandom());
               cz = 0;
            end
            9: begin
               cx = small_comp(2048);
               cy = small_comp(2048);
               cz = small_comp(2048);
            end
            default: begin
               cx = vm3_pkg::comp_type'($urandom());
               cy = vm3_pkg::comp_type'($urandom());
               cz = vm3_pkg::comp_type'($urandom());
            end
         endcase
         table_left--;
         last_flag = table_left == 0;
         if (last_flag) table_left = $urandom_range(40, 1);
         // first random row and one later on wait for a fully drained pipe
         queue_row(cx, cy, cz, last_flag, i == 0 || i == 1200);
      end

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (!(rows_to_send.size() == 0 && norm_expected.size() == 0 && !req_bus.valid)
             && stall_count < STALL_LIMIT)
         @(posedge clock);

      if (stall_count >= STALL_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, norm_expected.size());
         $display("** vector_magnitude_3d: FAILED **");
         $finish;
      end else begin
         repeat (TAIL_CYCLES) @(posedge clock);
         if (norm_expected.size() != 0)
            flag_fault($sformatf("%0d results never arrived", norm_expected.size()));
         $display("Sent %0d rows in %0d tables incl. extremes and zero; peak magnitude %0d.",
                  rows_in, table_ends, peak_mag);
         $display("Responses checked: %0d, mismatches: %0d.", rows_out, fault_count);
         if (fault_count == 0)
            $display("** vector_magnitude_3d: PASSED **");
         else
            $display("** vector_magnitude_3d: FAILED **");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
src/vm3_pkg.sv
src/vm3_req_if.sv
src/vm3_rsp_if.sv
src/vm3_sumsq.sv
src/vm3_sqrt_stage.sv
src/vector_magnitude_3d.sv
tb/sv/vector_magnitude_3d_test.sv
